// ===== hw/rtl/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared request/response types and codes for the register pool allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int VAR_ID_W = 16;
	localparam int REG_W    = 16;

	// request kinds
	localparam logic [1:0] REQ_GET     = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_TEMP    = 2'd2;

	// response status codes
	localparam logic [2:0] ST_NEW            = 3'd0;
	localparam logic [2:0] ST_EXISTING       = 3'd1;
	localparam logic [2:0] ST_RELEASED       = 3'd2;
	localparam logic [2:0] ST_NOT_MAPPED     = 3'd3;
	localparam logic [2:0] ST_MAP_FULL       = 3'd4;
	localparam logic [2:0] ST_VIRT_EXHAUSTED = 3'd5;

	// virtual numbering saturates here, this value is never handed out
	localparam logic [REG_W-1:0] VIRT_LIMIT = 16'hFFFF;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [VAR_ID_W-1:0] var_id;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             is_physical;
		logic [REG_W-1:0] reg_number;
	} rsp_t;

endpackage

// ===== hw/rtl/register_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// register_pool_allocator
// Maps variable ids to pool registers or virtual registers, with a LIFO free
// pool, a fully associative map and a saturating virtual register counter.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless the output stalls, set by the
// combinational map compare, first-free search and pool push/pop done
// between the input and output registers; the map's register field is a
// memory with a registered read.
// Reset: map valid bits and pool ownership clear at once, the pool reloads
// with t0..t9 (top is highest index), virtual counter goes to zero.
// ----------------------------------------------------------------------------
module register_pool_allocator #(
	parameter int POOL_SIZE   = 10,
	parameter int MAP_ENTRIES = 64,
	parameter int ID_BITS     = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rpa_pkg::rsp_t rsp
);

	localparam int KEY_W = (ID_BITS < rpa_pkg::VAR_ID_W) ? ID_BITS : rpa_pkg::VAR_ID_W;
	localparam int IW    = $clog2(MAP_ENTRIES);
	localparam int SIW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CW    = $clog2(POOL_SIZE + 1);
	localparam int MW    = rpa_pkg::REG_W + 1;

	// input stage
	rpa_pkg::req_t req_s1;
	logic          valid_s1;
	logic          adv;

	// map state
	logic [MAP_ENTRIES-1:0] entry_valid_q;
	logic [KEY_W-1:0]       entry_key_q [MAP_ENTRIES];
	logic [MW-1:0]          map_mem [MAP_ENTRIES];

	// pool state
	logic [SIW-1:0]       stack_q [POOL_SIZE];
	logic [CW-1:0]        free_cnt_q;
	logic [POOL_SIZE-1:0] phys_busy_q;
	logic [IW-1:0]        phys_owner_q [POOL_SIZE];

	logic [rpa_pkg::REG_W-1:0] virtual_next_q;

	// output stage
	logic                      rsp_valid_s2;
	logic [2:0]                status_s2;
	logic                      phys_s2;
	logic [rpa_pkg::REG_W-1:0] regn_s2;
	logic                      use_rd_s2;
	logic [MW-1:0]             rd_s2;

	// lookup results
	logic [KEY_W-1:0]       key;
	logic [MAP_ENTRIES-1:0] match;
	logic                   hit;
	logic [IW-1:0]          hit_idx;
	logic [MAP_ENTRIES-1:0] free_vec;
	logic [MAP_ENTRIES-1:0] first_free;
	logic [IW-1:0]          free_idx;
	logic                   map_full;
	logic [CW-1:0]          cnt_m1;
	logic [SIW-1:0]         top_reg;
	logic                   pool_nonempty;
	logic                   pool_full;
	logic                   virt_avail;
	logic [POOL_SIZE-1:0]   owner_match;
	logic                   hit_phys;
	logic [SIW-1:0]         push_reg;

	// decisions
	logic [2:0]                st_c;
	logic                      phys_c;
	logic [rpa_pkg::REG_W-1:0] regn_c;
	logic                      use_rd_c;
	logic                      do_alloc;
	logic                      alloc_phys;
	logic [rpa_pkg::REG_W-1:0] alloc_reg;
	logic                      do_pop;
	logic                      do_push;
	logic                      do_inval;
	logic                      do_virt;

	assign adv       = valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	assign key = req_s1.var_id[KEY_W-1:0];

	always_comb begin
		match   = '0;
		hit_idx = '0;
		for (int i = 0; i < MAP_ENTRIES; i++) begin
			match[i] = entry_valid_q[i] && (entry_key_q[i] == key);
			if (match[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
		end
	end
	assign hit = |match;

	// lowest free entry: isolate lowest set bit, then or-encode
	assign free_vec   = ~entry_valid_q;
	assign first_free = free_vec & (~free_vec + MAP_ENTRIES'(1));
	assign map_full   = (free_vec == '0);

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < MAP_ENTRIES; i++) begin
			if (first_free[i]) begin
				free_idx = free_idx | IW'(i);
			end
		end
	end

	assign cnt_m1        = free_cnt_q - CW'(1);
	assign top_reg       = stack_q[cnt_m1[SIW-1:0]];
	assign pool_nonempty = (free_cnt_q != '0);
	assign pool_full     = (free_cnt_q >= CW'(POOL_SIZE));
	assign virt_avail    = (virtual_next_q != rpa_pkg::VIRT_LIMIT);

	// which pool register, if any, belongs to the hit entry
	always_comb begin
		owner_match = '0;
		push_reg    = '0;
		for (int p = 0; p < POOL_SIZE; p++) begin
			owner_match[p] = phys_busy_q[p] && (phys_owner_q[p] == hit_idx);
			if (owner_match[p]) begin
				push_reg = push_reg | SIW'(p);
			end
		end
	end
	assign hit_phys = |owner_match;

	always_comb begin
		st_c       = rpa_pkg::ST_NOT_MAPPED;
		phys_c     = 1'b0;
		regn_c     = '0;
		use_rd_c   = 1'b0;
		do_alloc   = 1'b0;
		alloc_phys = 1'b0;
		alloc_reg  = '0;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		do_inval   = 1'b0;
		do_virt    = 1'b0;
		case (req_s1.req_type)
			rpa_pkg::REQ_GET: begin
				if (hit) begin
					st_c     = rpa_pkg::ST_EXISTING;
					use_rd_c = 1'b1;
				end else if (map_full) begin
					st_c = rpa_pkg::ST_MAP_FULL;
				end else if (pool_nonempty) begin
					st_c       = rpa_pkg::ST_NEW;
					alloc_phys = 1'b1;
					alloc_reg  = rpa_pkg::REG_W'(top_reg);
					do_alloc   = 1'b1;
					do_pop     = 1'b1;
				end else if (!virt_avail) begin
					st_c = rpa_pkg::ST_VIRT_EXHAUSTED;
				end else begin
					st_c      = rpa_pkg::ST_NEW;
					alloc_reg = virtual_next_q;
					do_alloc  = 1'b1;
					do_virt   = 1'b1;
				end
				phys_c = alloc_phys;
				regn_c = alloc_reg;
			end
			rpa_pkg::REQ_RELEASE: begin
				if (hit) begin
					st_c     = rpa_pkg::ST_RELEASED;
					use_rd_c = 1'b1;
					do_inval = 1'b1;
					do_push  = hit_phys && !pool_full;
				end
			end
			rpa_pkg::REQ_TEMP: begin
				if (!virt_avail) begin
					st_c = rpa_pkg::ST_VIRT_EXHAUSTED;
				end else begin
					st_c    = rpa_pkg::ST_NEW;
					regn_c  = virtual_next_q;
					do_virt = 1'b1;
				end
			end
			default: begin
				st_c = rpa_pkg::ST_NOT_MAPPED;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			rsp_valid_s2   <= 1'b0;
			entry_valid_q  <= '0;
			free_cnt_q     <= CW'(POOL_SIZE);
			phys_busy_q    <= '0;
			virtual_next_q <= '0;
			for (int p = 0; p < POOL_SIZE; p++) begin
				stack_q[p] <= SIW'(p);
			end
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_s2 <= 1'b0;
			end
			if (adv) begin
				if (do_alloc) begin
					entry_valid_q[free_idx] <= 1'b1;
				end
				if (do_inval) begin
					entry_valid_q[hit_idx] <= 1'b0;
				end
				if (do_pop) begin
					free_cnt_q           <= cnt_m1;
					phys_busy_q[top_reg] <= 1'b1;
				end
				if (do_inval) begin
					phys_busy_q <= phys_busy_q & ~owner_match;
				end
				if (do_push) begin
					stack_q[free_cnt_q[SIW-1:0]] <= push_reg;
					free_cnt_q                   <= free_cnt_q + CW'(1);
				end
				if (do_virt) begin
					virtual_next_q <= virtual_next_q + rpa_pkg::REG_W'(1);
				end
			end
		end
	end

	// payload registers and map storage
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (adv) begin
			status_s2 <= st_c;
			phys_s2   <= phys_c;
			regn_s2   <= regn_c;
			use_rd_s2 <= use_rd_c;
			if (use_rd_c) begin
				rd_s2 <= map_mem[hit_idx];
			end
			if (do_alloc) begin
				entry_key_q[free_idx] <= key;
				map_mem[free_idx]     <= {alloc_phys, alloc_reg};
			end
			if (do_pop) begin
				phys_owner_q[top_reg] <= free_idx;
			end
		end
	end

	assign rsp_valid       = rsp_valid_s2;
	assign rsp.status      = status_s2;
	assign rsp.is_physical = use_rd_s2 ? rd_s2[MW-1] : phys_s2;
	assign rsp.reg_number  = use_rd_s2 ? rd_s2[rpa_pkg::REG_W-1:0] : regn_s2;

	// every pool register is either on the free stack or owned by one entry
	a_pool_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		(32'($countones(phys_busy_q)) + 32'(free_cnt_q)) == 32'(POOL_SIZE))
		else $error("pool registers lost or duplicated");

	a_phys_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_physical) |-> (32'(rsp.reg_number) < 32'(POOL_SIZE)))
		else $error("physical register index out of pool range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == rpa_pkg::ST_MAP_FULL
			|| rsp.status == rpa_pkg::ST_VIRT_EXHAUSTED
			|| rsp.status == rpa_pkg::ST_NOT_MAPPED))
		|-> (!rsp.is_physical && rsp.reg_number == '0))
		else $error("failed request returned a register");

	a_full_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && map_full) |=> (entry_valid_q == $past(entry_valid_q)
			|| $past(do_inval)))
		else $error("map entry allocated while map full");

endmodule
